// ----- sv/jexif_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG EXIF locator package
// Shared codes, constants and types of the EXIF header locator.
// ----------------------------------------------------------------------------
package jexif_pkg;

   typedef logic [2:0] status_type;

   localparam status_type ST_FOUND      = 3'd0;
   localparam status_type ST_TRUNC      = 3'd1;
   localparam status_type ST_NO_SOI     = 3'd2;
   localparam status_type ST_BAD_MARKER = 3'd3;
   localparam status_type ST_NO_EXIF    = 3'd4;
   localparam status_type ST_BAD_HEADER = 3'd5;
   localparam status_type ST_BAD_TIFF   = 3'd6;
   localparam status_type ST_SHORT      = 3'd7;

   localparam logic [7:0]  MARKER_PREFIX   = 8'hFF;
   localparam logic [7:0]  SOI_CODE        = 8'hD8;
   localparam logic [7:0]  APP1_CODE       = 8'hE1;
   localparam logic [7:0]  SOS_CODE        = 8'hDA;
   localparam logic [7:0]  ORDER_MM_CHAR   = 8'h4D;
   localparam logic [7:0]  TIFF_MAGIC      = 8'h2A;
   localparam logic [15:0] MIN_APP1_LENGTH = 16'd16;
   localparam logic [15:0] MIN_SEG_LENGTH  = 16'd2;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_SOI  = 6'b000010,
      PH_MARK = 6'b000100,
      PH_SKIP = 6'b001000,
      PH_EXIF = 6'b010000,
      PH_TIFF = 6'b100000
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic        big_endian;
      logic [31:0] first_dir_offset;
      logic [15:0] app1_length;
   } result_type;

   // "Exif\0\0" header bytes by position.
   function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
      logic [7:0] sig;
      unique case (idx)
         3'd0: sig = 8'h45;
         3'd1: sig = 8'h78;
         3'd2: sig = 8'h69;
         3'd3: sig = 8'h66;
         default: sig = 8'h00;
      endcase
      return sig;
   endfunction

endpackage

// ----- sv/jexif_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG EXIF locator parser
// Parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module jexif_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             data_byte,
   input  logic                   first_of_file,
   input  logic                   last_of_file,
   output logic                   result_valid,
   output jexif_pkg::result_type  result
);
   import jexif_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic [15:0] skip_ff, skip_in;
   logic        big_ff, big_in;
   logic [31:0] acc_ff, acc_in;

   always_comb begin
      phase_type   ph;
      logic [2:0]  pos;
      logic [7:0]  mk;
      logic [15:0] seg;
      logic [15:0] skp;
      logic        big;
      logic [31:0] acc;
      logic        hit;
      status_type  st;
      logic [15:0] seg_full;

      ph  = phase_ff;
      pos = pos_ff;
      mk  = marker_ff;
      seg = seg_len_ff;
      skp = skip_ff;
      big = big_ff;
      acc = acc_ff;
      hit = 1'b0;
      st  = ST_TRUNC;
      seg_full = '0;

      if (first_of_file) begin
         ph  = PH_SOI;
         pos = '0;
         mk  = '0;
         seg = '0;
         skp = '0;
         big = 1'b0;
         acc = '0;
      end

      unique case (ph)
         PH_IDLE: begin
         end
         PH_SOI: begin
            if (pos == 3'd0) begin
               if (data_byte != MARKER_PREFIX) begin
                  hit = 1'b1;
                  st  = ST_NO_SOI;
               end else begin
                  pos = 3'd1;
               end
            end else begin
               if (data_byte != SOI_CODE) begin
                  hit = 1'b1;
                  st  = ST_NO_SOI;
               end else begin
                  pos = 3'd0;
                  ph  = PH_MARK;
               end
            end
         end
         PH_MARK: begin
            priority case (pos)
               3'd0: begin
                  if (data_byte != MARKER_PREFIX) begin
                     hit = 1'b1;
                     st  = ST_BAD_MARKER;
                  end else begin
                     pos = 3'd1;
                  end
               end
               3'd1: begin
                  mk  = data_byte;
                  pos = 3'd2;
               end
               3'd2: begin
                  seg = {data_byte, 8'h00};
                  pos = 3'd3;
               end
               default: begin
                  seg_full = {seg[15:8], data_byte};
                  seg = seg_full;
                  pos = 3'd0;
                  if (mk == APP1_CODE) begin
                     if (seg_full < MIN_APP1_LENGTH) begin
                        hit = 1'b1;
                        st  = ST_SHORT;
                     end else begin
                        ph = PH_EXIF;
                     end
                  end else if (mk == SOS_CODE) begin
                     hit = 1'b1;
                     st  = ST_NO_EXIF;
                  end else if (seg_full < MIN_SEG_LENGTH) begin
                     hit = 1'b1;
                     st  = ST_SHORT;
                  end else begin
                     skp = seg_full - MIN_SEG_LENGTH;
                     ph  = (skp == 16'd0) ? PH_MARK : PH_SKIP;
                  end
               end
            endcase
         end
         PH_SKIP: begin
            skp = skp - 16'd1;
            if (skp == 16'd0) begin
               ph  = PH_MARK;
               pos = 3'd0;
            end
         end
         PH_EXIF: begin
            if (pos > 3'd5 || data_byte != exif_sig_byte(pos)) begin
               hit = 1'b1;
               st  = ST_BAD_HEADER;
            end else if (pos == 3'd5) begin
               pos = 3'd0;
               ph  = PH_TIFF;
            end else begin
               pos = pos + 3'd1;
            end
         end
         PH_TIFF: begin
            priority case (pos)
               3'd0: big = (data_byte == ORDER_MM_CHAR);
               3'd1: begin
                  if (data_byte != ORDER_MM_CHAR) big = 1'b0;
               end
               3'd2: begin
                  if (data_byte != (big ? 8'h00 : TIFF_MAGIC)) begin
                     hit = 1'b1;
                     st  = ST_BAD_TIFF;
                  end
               end
               3'd3: begin
                  if (data_byte != (big ? TIFF_MAGIC : 8'h00)) begin
                     hit = 1'b1;
                     st  = ST_BAD_TIFF;
                  end
               end
               default: begin
                  acc = big ? {acc[23:0], data_byte} : {data_byte, acc[31:8]};
                  if (pos == 3'd7) begin
                     hit = 1'b1;
                     st  = ST_FOUND;
                  end
               end
            endcase
            if (!hit) pos = pos + 3'd1;
         end
         default: begin
            hit = 1'b1;
            st  = ST_TRUNC;
         end
      endcase

      // Truncation: an active parse that ends here without another outcome.
      if (!hit && last_of_file && ph != PH_IDLE) begin
         hit = 1'b1;
         st  = ST_TRUNC;
      end

      result_valid            = fire && hit;
      result.status           = st;
      result.big_endian       = (st == ST_FOUND) ? big : 1'b0;
      result.first_dir_offset = (st == ST_FOUND) ? acc : 32'd0;
      result.app1_length      = (st == ST_FOUND) ? seg : 16'd0;

      // Any outcome drops the parse back to idle.
      if (hit) begin
         ph  = PH_IDLE;
         pos = '0;
         mk  = '0;
         seg = '0;
         skp = '0;
         big = 1'b0;
         acc = '0;
      end

      if (fire) begin
         phase_in   = ph;
         pos_in     = pos;
         marker_in  = mk;
         seg_len_in = seg;
         skip_in    = skp;
         big_in     = big;
         acc_in     = acc;
      end else begin
         phase_in   = phase_ff;
         pos_in     = pos_ff;
         marker_in  = marker_ff;
         seg_len_in = seg_len_ff;
         skip_in    = skip_ff;
         big_in     = big_ff;
         acc_in     = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         marker_ff  <= '0;
         seg_len_ff <= '0;
         skip_ff    <= '0;
         big_ff     <= 1'b0;
         acc_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         marker_ff  <= marker_in;
         seg_len_ff <= seg_len_in;
         skip_ff    <= skip_in;
         big_ff     <= big_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

// ----- sv/jpeg_exif_header_locator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG EXIF header locator
// Scans a JPEG byte stream for the APP1 EXIF segment and the first IFD offset.
// ----------------------------------------------------------------------------
// Feed a JPEG file one byte per req beat, with req_first_of_file on its first
// byte and req_last_of_file on its last. The block checks the FF D8 start
// marker, skips marker segments by their big-endian length, and at APP1 checks
// the "Exif\0\0" header, the TIFF byte order (MM is big endian) and magic 42,
// then assembles the 32-bit first-IFD offset. Each file gives at most one rsp
// beat with a status code, exactly one if req_last_of_file marks its end;
// big_endian, first_dir_offset and app1_length are nonzero only with status
// found. A start of scan before APP1 reports no exif. Bytes that arrive after
// the result and before the next first-of-file byte are dropped without a
// beat. Rate: one byte per cycle sustained; a byte passes from req to rsp
// through the input register and then through the parser into the result
// register. Only a stalled result register holds the pipe back.
// ----------------------------------------------------------------------------
module jpeg_exif_header_locator_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_of_file,
   input  logic                   req_last_of_file,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jexif_pkg::status_type  rsp_status,
   output logic                   rsp_big_endian,
   output logic [31:0]            rsp_first_dir_offset,
   output logic [15:0]            rsp_app1_length
);
   import jexif_pkg::*;

   // Input register: one byte waiting for the parser.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       advance;
   logic       parse_fire;
   logic       req_take;
   logic       res_valid;
   result_type res;

   // The parser moves one byte whenever the result register can take a beat.
   assign advance    = !out_valid_ff || !rsp_stall;
   assign parse_fire = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (parse_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load a new result on advance; hold while the consumer stalls.
   assign out_valid_in = advance ? (parse_fire && res_valid) : out_valid_ff;

   jexif_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (parse_fire),
      .data_byte     (in_byte_ff),
      .first_of_file (in_first_ff),
      .last_of_file  (in_last_ff),
      .result_valid  (res_valid),
      .result        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_of_file;
         in_last_ff  <= req_last_of_file;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_ff.status;
   assign rsp_big_endian       = out_ff.big_endian;
   assign rsp_first_dir_offset = out_ff.first_dir_offset;
   assign rsp_app1_length      = out_ff.app1_length;

endmodule

// ----- sim/jpeg_exif_header_locator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG EXIF header locator testbench
// Streams short JPEG files into the locator byte by byte, predicts the status
// beat, if any, each file yields, and checks every rsp beat field by field.
// ----------------------------------------------------------------------------

module jpeg_exif_header_locator_top_tb;
   import jexif_pkg::*;

   localparam logic [47:0] EXIF_HDR  = 48'h4578_6966_0000;
   localparam int          NO_RESULT = -1;

   // Tracks the parse of the current file and holds the headers still owed.
   class exif_result_board;
      phase_type   phase;
      logic [3:0]  pos;
      logic [7:0]  code;
      logic [15:0] seg_len;
      logic [15:0] skip_left;
      bit          big;
      logic [31:0] offset;
      bit          done;
      result_type  expected_headers[$];
      int          errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         phase     = PH_IDLE;
         pos       = '0;
         code      = '0;
         seg_len   = '0;
         skip_left = '0;
         big       = 1'b0;
         offset    = '0;
         done      = 1'b1;
      endfunction

      function int marker_step(logic [7:0] b);
         case (pos)
            4'd0: begin
               if (b != MARKER_PREFIX) return ST_BAD_MARKER;
               pos = 4'd1;
            end
            4'd1: begin
               code = b;
               pos  = 4'd2;
            end
            4'd2: begin
               seg_len = {b, 8'h00};
               pos     = 4'd3;
            end
            default: begin
               seg_len = {seg_len[15:8], b};
               pos     = 4'd0;
               if (code == APP1_CODE) begin
                  if (seg_len < MIN_APP1_LENGTH) return ST_SHORT;
                  phase = PH_EXIF;
                  return NO_RESULT;
               end
               if (code == SOS_CODE) return ST_NO_EXIF;
               if (seg_len < MIN_SEG_LENGTH) return ST_SHORT;
               skip_left = seg_len - MIN_SEG_LENGTH;
               phase     = (skip_left == 0) ? PH_MARK : PH_SKIP;
            end
         endcase
         return NO_RESULT;
      endfunction

      function int tiff_step(logic [7:0] b);
         if (pos == 0) begin
            big = (b == ORDER_MM_CHAR);
         end else if (pos == 1) begin
            if (b != ORDER_MM_CHAR) big = 1'b0;
         end else if (pos == 2) begin
            if (b != (big ? 8'h00 : TIFF_MAGIC)) return ST_BAD_TIFF;
         end else if (pos == 3) begin
            if (b != (big ? TIFF_MAGIC : 8'h00)) return ST_BAD_TIFF;
         end else begin
            offset = big ? {offset[23:0], b} : {b, offset[31:8]};
            if (pos >= 7) return ST_FOUND;
         end
         pos = pos + 4'd1;
         return NO_RESULT;
      endfunction

      // Advance the parse by one accepted byte; returns 0 when the byte is dropped.
      function bit note_byte(logic [7:0] b, bit first, bit last);
         int         st;
         result_type hdr;
         st = NO_RESULT;
         if (first) begin
            clear();
            done  = 1'b0;
            phase = PH_SOI;
         end
         if (done) return 1'b0;
         case (phase)
            PH_SOI: begin
               if (pos == 0) begin
                  if (b != MARKER_PREFIX) st = ST_NO_SOI;
                  else pos = 4'd1;
               end else begin
                  if (b != SOI_CODE) st = ST_NO_SOI;
                  else begin
                     pos   = 4'd0;
                     phase = PH_MARK;
                  end
               end
            end
            PH_MARK: st = marker_step(b);
            PH_SKIP: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) begin
                  phase = PH_MARK;
                  pos   = 4'd0;
               end
            end
            PH_EXIF: begin
               if (pos > 5 || b != EXIF_HDR[47 - 8 * pos -: 8]) st = ST_BAD_HEADER;
               else if (pos == 5) begin
                  pos   = 4'd0;
                  phase = PH_TIFF;
               end else pos = pos + 4'd1;
            end
            PH_TIFF: st = tiff_step(b);
            default: st = ST_TRUNC;
         endcase
         if (st == NO_RESULT && last) st = ST_TRUNC;
         if (st != NO_RESULT) begin
            hdr        = '0;
            hdr.status = status_type'(st);
            if (st == ST_FOUND) begin
               hdr.big_endian       = big;
               hdr.first_dir_offset = offset;
               hdr.app1_length      = seg_len;
            end
            expected_headers.push_back(hdr);
            clear();
         end
         return 1'b1;
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         end
      endfunction

      function void check_header(result_type got);
         result_type want;
         if (expected_headers.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat, expected none, actual status %0d",
                     $time, got.status);
            return;
         end
         want = expected_headers.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("big_endian", 32'(want.big_endian), 32'(got.big_endian));
         compare_field("first_dir_offset", want.first_dir_offset, got.first_dir_offset);
         compare_field("app1_length", 32'(want.app1_length), 32'(got.app1_length));
      endfunction
   endclass

   localparam int BYTE_TARGET = 1150;
   localparam int CALM_BYTES  = 150;
   localparam int DRAIN       = 20;
   localparam int CYCLE_LIMIT = 400_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_of_file = 1'b0;
   logic        req_last_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   status_type  rsp_status;
   logic        rsp_big_endian;
   logic [31:0] rsp_first_dir_offset;
   logic [15:0] rsp_app1_length;

   exif_result_board board = new();

   // Idling knobs: reshuffled per file, both overridden by calm near the end.
   bit src_idle  = 1'b0;
   bit sink_idle = 1'b0;
   bit calm      = 1'b0;
   int bytes_used = 0;
   int stall_left = 0;
   int cycles = 0;

   jpeg_exif_header_locator_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_first_of_file    (req_first_of_file),
      .req_last_of_file     (req_last_of_file),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_big_endian       (rsp_big_endian),
      .rsp_first_dir_offset (rsp_first_dir_offset),
      .rsp_app1_length      (rsp_app1_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the pipe hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: check each accepted beat using pre-edge values, then pick the
   // stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_header(result_type'({rsp_status, rsp_big_endian,
                                           rsp_first_dir_offset, rsp_app1_length}));
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (sink_idle && !calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one byte, maybe after an idle gap, and hold it until accepted.
   // Valid stays high into the next byte when there is no gap.
   task automatic push_byte(input logic [7:0] b, input bit first, input bit last);
      int gap;
      gap = 0;
      if (src_idle && !calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_first_of_file <= first;
      req_last_of_file  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (board.note_byte(b, first, last)) bytes_used++;
   endtask

   // Build a mostly well-formed JPEG head: SOI, a few skipped segments, then
   // APP1 with the Exif and TIFF headers, or a start of scan. Bad bytes are
   // sprinkled in at every stage; huge segments are cut short.
   task automatic build_file(ref logic [7:0] f[$]);
      int          nseg;
      int          pick;
      int          n;
      logic [15:0] len;
      logic [7:0]  code;
      bit          big;
      f.delete();
      pick = $urandom_range(0, 99);
      f.push_back(pick < 4 ? 8'($urandom) : MARKER_PREFIX);
      f.push_back((pick >= 4 && pick < 8) ? 8'($urandom) : SOI_CODE);
      nseg = $urandom_range(0, 3);
      for (int s = 0; s < nseg; s++) begin
         f.push_back($urandom_range(0, 29) == 0 ? 8'($urandom) : MARKER_PREFIX);
         code = 8'($urandom);
         if (code == APP1_CODE || code == SOS_CODE) code ^= 8'h01;
         f.push_back(code);
         pick = $urandom_range(0, 9);
         len  = (pick == 0) ? 16'($urandom_range(0, 1)) :
                (pick == 1) ? 16'($urandom) : 16'($urandom_range(2, 10));
         f.push_back(len[15:8]);
         f.push_back(len[7:0]);
         if (len < MIN_SEG_LENGTH) return;
         n = len - 2;
         if (n > 24) begin
            repeat ($urandom_range(0, 24)) f.push_back(8'($urandom));
            return;
         end
         repeat (n) f.push_back(8'($urandom));
      end
      if ($urandom_range(0, 6) == 0) begin
         f.push_back(MARKER_PREFIX);
         f.push_back(SOS_CODE);
         f.push_back(8'($urandom));
         f.push_back(8'($urandom));
         repeat ($urandom_range(0, 3)) f.push_back(8'($urandom));
         return;
      end
      f.push_back(MARKER_PREFIX);
      f.push_back(APP1_CODE);
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? 16'($urandom_range(0, 15)) :
             (pick == 1) ? 16'($urandom) : 16'($urandom_range(16, 64));
      f.push_back(len[15:8]);
      f.push_back(len[7:0]);
      for (int i = 0; i < 6; i++)
         f.push_back($urandom_range(0, 39) == 0 ? 8'($urandom) : EXIF_HDR[47 - 8 * i -: 8]);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         f.push_back(ORDER_MM_CHAR);
         f.push_back(ORDER_MM_CHAR);
      end else if (pick < 8) begin
         f.push_back(8'h49);
         f.push_back(8'h49);
      end else begin
         f.push_back($urandom_range(0, 1) ? ORDER_MM_CHAR : 8'($urandom));
         f.push_back($urandom_range(0, 1) ? ORDER_MM_CHAR : 8'($urandom));
      end
      big = (f[f.size() - 2] == ORDER_MM_CHAR) && (f[f.size() - 1] == ORDER_MM_CHAR);
      f.push_back($urandom_range(0, 11) == 0 ? 8'($urandom) : (big ? 8'h00 : TIFF_MAGIC));
      f.push_back($urandom_range(0, 11) == 0 ? 8'($urandom) : (big ? TIFF_MAGIC : 8'h00));
      repeat (4) f.push_back(8'($urandom));
      repeat ($urandom_range(0, 4)) f.push_back(8'($urandom));
   endtask

   initial begin
      logic [7:0] file[$];
      logic [7:0] hit[20];
      int         cut;
      bit         mark_last;

      // Big-endian hit with every offset and length bit set.
      hit = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'hFF, 8'hFF,
              8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00,
              8'h4D, 8'h4D, 8'h00, 8'h2A, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: a stray byte while idle (dropped even with last set), a
      // one-byte file with a bad SOI, a file cut right after SOI, then a hit.
      push_byte(8'h5A, 1'b0, 1'b1);
      push_byte(8'h00, 1'b1, 1'b1);
      push_byte(MARKER_PREFIX, 1'b1, 1'b0);
      push_byte(SOI_CODE, 1'b0, 1'b1);
      foreach (hit[i]) push_byte(hit[i], i == 0, i == 19);

      // Random files; some lose their tail, some their last flag, some get a
      // corrupted byte, and stray bytes may sit between them.
      while (bytes_used < BYTE_TARGET) begin
         src_idle  = $urandom_range(0, 3) != 0;
         sink_idle = $urandom_range(0, 3) != 0;
         calm      = bytes_used > BYTE_TARGET - CALM_BYTES;
         build_file(file);
         if ($urandom_range(0, 9) == 0) file[$urandom_range(0, file.size() - 1)] = 8'($urandom);
         cut = file.size();
         if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, file.size());
         mark_last = $urandom_range(0, 7) != 0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom));
         for (int i = 0; i < cut; i++) push_byte(file[i], i == 0, mark_last && i == cut - 1);
      end
      req_valid <= 1'b0;

      // Drain: wait for the owed headers, then give the pipe time to show
      // any stray beat.
      while (board.expected_headers.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (board.expected_headers.size() > 0)
         $display("%0t: %0d expected headers never arrived", $time,
                  board.expected_headers.size());
      if (board.errors == 0 && board.expected_headers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
